FILE: rtl/core/djss_pkg.sv
`default_nettype none
package djss_pkg;

  localparam int NUM_SLOTS   = 64;
  localparam int PROFIT_BITS = 16;

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TREE_N = 1 << IDX_W;
  localparam int DL_W   = 9;

  localparam int REQ_W  = 2;
  localparam int ID_W   = 8;
  localparam int PROF_W = 16;
  localparam int DLIN_W = 8;
  localparam int SLOT_W = 6;
  localparam int SUM_W  = 24;

  localparam logic [PROF_W-1:0] PROF_MASK =
    (PROFIT_BITS >= PROF_W) ? {PROF_W{1'b1}} :
    PROF_W'((64'd1 << PROFIT_BITS) - 64'd1);

  typedef enum logic [REQ_W-1:0] {
    REQ_OFFER = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  function automatic logic [IDX_W-1:0] slot_addr(input logic [SLOT_W-1:0] si);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{IDX_W{1'b0}}, si};
    return w[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/djss_ram.sv
`default_nettype none
module djss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/djss_ctrl.sv
`default_nettype none
module djss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output djss_pkg::cmd_t     cmd
);

  djss_pkg::state_t state;
  djss_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      djss_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = djss_pkg::ST_EXEC;
        end
      end
      djss_pkg::ST_EXEC: begin
        state_next = djss_pkg::ST_OUT;
      end
      djss_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = in_valid ? djss_pkg::ST_EXEC : djss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = djss_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = !((state == djss_pkg::ST_IDLE) ||
                    ((state == djss_pkg::ST_OUT) && !out_stall));
    out_valid   = (state == djss_pkg::ST_OUT);
    cmd.capture = in_valid && !in_stall;
    cmd.exec    = (state == djss_pkg::ST_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= djss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.exec)
    else $error("captured request not executed");
  a_exec_out: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("executed request gave no result");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !cmd.capture)
    else $error("request taken while result stalled");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/djss_datapath.sv
`default_nettype none
module djss_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire djss_pkg::cmd_t                cmd,
  input  wire logic [djss_pkg::REQ_W-1:0]    req_type,
  input  wire logic [djss_pkg::ID_W-1:0]     job_id,
  input  wire logic [djss_pkg::PROF_W-1:0]   job_profit,
  input  wire logic [djss_pkg::DLIN_W-1:0]   job_deadline,
  input  wire logic [djss_pkg::SLOT_W-1:0]   slot_index,
  output logic                               was_placed,
  output logic      [djss_pkg::SLOT_W-1:0]   placed_slot,
  output logic      [djss_pkg::SUM_W-1:0]    total_profit,
  output logic      [djss_pkg::ID_W-1:0]     slot_job
);

  localparam int IDX_W  = djss_pkg::IDX_W;
  localparam int TREE_N = djss_pkg::TREE_N;
  localparam int NS     = djss_pkg::NUM_SLOTS;
  localparam int DL_W   = djss_pkg::DL_W;
  localparam int SUM_W  = djss_pkg::SUM_W;
  localparam int SLOT_W = djss_pkg::SLOT_W;
  localparam int ID_W   = djss_pkg::ID_W;

  logic [djss_pkg::REQ_W-1:0]  req_q;
  logic [ID_W-1:0]             id_q;
  logic [djss_pkg::PROF_W-1:0] prof_q;
  logic [DL_W-1:0]             dl_q;
  logic [IDX_W-1:0]            addr_q;
  logic                        inrange_q;

  logic [NS-1:0]    busy;
  logic [NS-1:0]    busy_next;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;

  logic [DL_W-1:0]  dl_ext;
  logic [NS-1:0]    free;
  logic [TREE_N-1:0] free_pad;
  logic             val [IDX_W+1][TREE_N];
  logic [IDX_W-1:0] ix  [IDX_W+1][TREE_N];
  logic             found;
  logic [IDX_W-1:0] pos;
  logic [IDX_W+SLOT_W-1:0] pos_ext;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_sat;

  logic              placed_n;
  logic [SLOT_W-1:0] slot_n;
  logic [ID_W-1:0]   job_n;
  logic              we;
  logic [ID_W-1:0]   rdata;

  assign dl_ext = {1'b0, job_deadline};

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      free[k] = !busy[k] && (DL_W'(k) < dl_q);
    end
    free_pad = TREE_N'(free);
    for (int i = 0; i < TREE_N; i++) begin
      for (int l = 0; l <= IDX_W; l++) begin
        val[l][i] = 1'b0;
        ix[l][i]  = '0;
      end
    end
    for (int i = 0; i < TREE_N; i++) begin
      val[0][i] = free_pad[i];
      ix[0][i]  = IDX_W'(i);
    end
    for (int l = 1; l <= IDX_W; l++) begin
      for (int n = 0; n < (TREE_N >> l); n++) begin
        val[l][n] = val[l-1][2*n+1] || val[l-1][2*n];
        ix[l][n]  = val[l-1][2*n+1] ? ix[l-1][2*n+1] : ix[l-1][2*n];
      end
    end
    found   = val[IDX_W][0];
    pos     = ix[IDX_W][0];
    pos_ext = {{SLOT_W{1'b0}}, pos};
  end

  always_comb begin
    sum_add = {1'b0, sum} + (SUM_W+1)'(prof_q & djss_pkg::PROF_MASK);
    sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  end

  always_comb begin
    busy_next = busy;
    sum_next  = sum;
    placed_n  = 1'b0;
    slot_n    = '0;
    job_n     = '0;
    we        = 1'b0;
    unique case (req_q)
      djss_pkg::REQ_OFFER: begin
        if (found) begin
          busy_next[pos] = 1'b1;
          sum_next       = sum_sat;
          placed_n       = 1'b1;
          slot_n         = pos_ext[SLOT_W-1:0];
          we             = cmd.exec;
        end
      end
      djss_pkg::REQ_READ: begin
        if (inrange_q && busy[addr_q]) begin
          job_n = rdata;
        end
      end
      djss_pkg::REQ_CLEAR: begin
        busy_next = '0;
        sum_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q     <= req_type;
      id_q      <= job_id;
      prof_q    <= job_profit;
      dl_q      <= (dl_ext > DL_W'(NS)) ? DL_W'(NS) : dl_ext;
      addr_q    <= djss_pkg::slot_addr(slot_index);
      inrange_q <= ({3'b000, slot_index} < DL_W'(NS));
    end
    if (cmd.exec) begin
      was_placed   <= placed_n;
      placed_slot  <= slot_n;
      total_profit <= sum_next;
      slot_job     <= job_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      sum  <= '0;
    end else if (cmd.exec) begin
      busy <= busy_next;
      sum  <= sum_next;
    end
  end

  djss_ram #(
    .WIDTH (ID_W),
    .DEPTH (NS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (pos),
    .wdata (id_q),
    .raddr (djss_pkg::slot_addr(slot_index)),
    .rdata (rdata)
  );

`ifndef NO_ASSERTIONS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (req_q == djss_pkg::REQ_CLEAR) |=> (busy == '0) && (sum == '0))
    else $error("clear left slots or total");
  a_place_free: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && we |-> !busy[pos] && (DL_W'(pos) < dl_q))
    else $error("job placed in busy or late slot");
  a_busy_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && we |=> busy[$past(pos)])
    else $error("placed slot not marked busy");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/deadline_job_slot_scheduler.sv
`default_nettype none
// Greedy deadline job scheduler over a table of time slots.
// Request channel: in_valid/in_stall with req_type, job_id, job_profit,
// job_deadline and slot_index. A request is taken at a clock edge with
// in_valid high and in_stall low. req_type selects offer, read or clear;
// other codes change nothing. Result channel: out_valid/out_stall with
// was_placed, placed_slot, total_profit and slot_job, one result per
// request, in request order. The request register feeds the execute state
// (free-slot priority tree over the busy bitmap, slot RAM write or
// registered RAM read), then the result register. No new request is taken
// while one is in execution or its result is stalled.
// A new request is taken in the same cycle the result is taken.
// While out_stall is high the result holds and in_stall stays high.
// Reset (rst, synchronous): all slots empty, total zero, no result
// pending; requests are taken in the first cycle after reset.
module deadline_job_slot_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [djss_pkg::REQ_W-1:0]    req_type,
  input  wire logic [djss_pkg::ID_W-1:0]     job_id,
  input  wire logic [djss_pkg::PROF_W-1:0]   job_profit,
  input  wire logic [djss_pkg::DLIN_W-1:0]   job_deadline,
  input  wire logic [djss_pkg::SLOT_W-1:0]   slot_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               was_placed,
  output logic      [djss_pkg::SLOT_W-1:0]   placed_slot,
  output logic      [djss_pkg::SUM_W-1:0]    total_profit,
  output logic      [djss_pkg::ID_W-1:0]     slot_job
);

  djss_pkg::cmd_t cmd;

  djss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  djss_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req_type),
    .job_id       (job_id),
    .job_profit   (job_profit),
    .job_deadline (job_deadline),
    .slot_index   (slot_index),
    .was_placed   (was_placed),
    .placed_slot  (placed_slot),
    .total_profit (total_profit),
    .slot_job     (slot_job)
  );

endmodule
`default_nettype wire

FILE: test/tb_deadline_job_slot_scheduler.sv
`default_nettype none
module tb_deadline_job_slot_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import djss_pkg::*;

  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
  localparam logic [SUM_W-1:0] SUM_LIMIT = '1;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 90;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic              placed;
    logic [SLOT_W-1:0] slot;
    logic [SUM_W-1:0]  sum;
    logic [ID_W-1:0]   job;
  } sched_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]  rt;
    logic [ID_W-1:0]   id;
    logic [PROF_W-1:0] profit;
    logic [DLIN_W-1:0] deadline;
    logic [SLOT_W-1:0] idx;
    logic              typed;
    sched_result_t     res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_W-1:0] req_type = '0;
  logic [ID_W-1:0] job_id = '0;
  logic [PROF_W-1:0] job_profit = '0;
  logic [DLIN_W-1:0] job_deadline = '0;
  logic [SLOT_W-1:0] slot_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic was_placed;
  logic [SLOT_W-1:0] placed_slot;
  logic [SUM_W-1:0] total_profit;
  logic [ID_W-1:0] slot_job;

  logic [ID_W-1:0] slot_ids_pred [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] busy_pred;
  logic [SUM_W-1:0] sum_pred;

  sched_result_t awaited_results [$];
  stim_row_t directed_rows [$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  deadline_job_slot_scheduler DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .job_id(job_id),
    .job_profit(job_profit),
    .job_deadline(job_deadline),
    .slot_index(slot_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .was_placed(was_placed),
    .placed_slot(placed_slot),
    .total_profit(total_profit),
    .slot_job(slot_job)
  );

  always #2 clk = ~clk;

  function automatic void clear_schedule();
    for (int k = 0; k < NUM_SLOTS; k++) slot_ids_pred[k] = '0;
    busy_pred = '0;
    sum_pred = '0;
  endfunction

  function automatic sched_result_t schedule_request(
    input logic [REQ_W-1:0] rt, input logic [ID_W-1:0] id, input logic [PROF_W-1:0] profit,
    input logic [DLIN_W-1:0] deadline, input logic [SLOT_W-1:0] idx);
    sched_result_t r;
    int lim;
    logic [SUM_W:0] s;
    r = '0;
    case (rt)
      REQ_OFFER: begin
        lim = (int'(deadline) > NUM_SLOTS) ? NUM_SLOTS : int'(deadline);
        for (int k = lim - 1; k >= 0 && !r.placed; k--) begin
          if (!busy_pred[k]) begin
            busy_pred[k] = 1'b1;
            slot_ids_pred[k] = id;
            s = {1'b0, sum_pred} + (SUM_W+1)'(profit & PROF_MASK);
            sum_pred = (s > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : s[SUM_W-1:0];
            r.placed = 1'b1;
            r.slot = k[SLOT_W-1:0];
          end
        end
      end
      REQ_READ: begin
        if (int'(idx) < NUM_SLOTS) r.job = slot_ids_pred[idx];
      end
      REQ_CLEAR: begin
        clear_schedule();
      end
      default: ;
    endcase
    r.sum = sum_pred;
    return r;
  endfunction

  function automatic stim_row_t row(
    input logic [REQ_W-1:0] rt, input logic [ID_W-1:0] id, input logic [PROF_W-1:0] profit,
    input logic [DLIN_W-1:0] deadline, input logic [SLOT_W-1:0] idx, input logic typed,
    input logic placed, input logic [SLOT_W-1:0] slot, input logic [SUM_W-1:0] sum,
    input logic [ID_W-1:0] job);
    stim_row_t r;
    r.rt = rt;
    r.id = id;
    r.profit = profit;
    r.deadline = deadline;
    r.idx = idx;
    r.typed = typed;
    r.res.placed = placed;
    r.res.slot = slot;
    r.res.sum = sum;
    r.res.job = job;
    return r;
  endfunction

  task automatic issue_request(input stim_row_t r);
    sched_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.rt;
    job_id <= r.id;
    job_profit <= r.profit;
    job_deadline <= r.deadline;
    slot_index <= r.idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = schedule_request(r.rt, r.id, r.profit, r.deadline, r.idx);
    awaited_results.push_back(r.typed ? r.res : predicted);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left == 0 && !hold_done && results_checked >= HOLD_AFTER && in_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    sched_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        e = awaited_results.pop_front();
        if (was_placed !== e.placed) begin
          $error("was_placed: expected %0d, got %0d", e.placed, was_placed);
          mismatches++;
        end
        if (placed_slot !== e.slot) begin
          $error("placed_slot: expected %0d, got %0d", e.slot, placed_slot);
          mismatches++;
        end
        if (total_profit !== e.sum) begin
          $error("total_profit: expected %0d, got %0d", e.sum, total_profit);
          mismatches++;
        end
        if (slot_job !== e.job) begin
          $error("slot_job: expected %0d, got %0d", e.job, slot_job);
          mismatches++;
        end
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t r;
    int issued;
    int batch_no;
    int batch_len;
    int pick;
    int profit_level;
    clear_schedule();

    directed_rows.push_back(row(REQ_READ,  8'h00, 16'h0000, 8'd0,   6'd0,  1, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_OFFER, 8'hFF, 16'hFFFF, 8'd0,   6'd0,  1, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_OFFER, 8'h01, 16'hFFFF, 8'd255, 6'd0,  1, 1, 63, 65535, 0));
    directed_rows.push_back(row(REQ_OFFER, 8'h00, 16'h0001, 8'd64,  6'd0,  1, 1, 62, 65536, 0));
    directed_rows.push_back(row(REQ_READ,  8'h00, 16'h0000, 8'd0,   6'd62, 1, 0, 0,  65536, 0));
    directed_rows.push_back(row(REQ_READ,  8'h00, 16'h0000, 8'd0,   6'd63, 1, 0, 0,  65536, 1));
    directed_rows.push_back(row(REQ_OFFER, 8'hAA, 16'h5555, 8'd1,   6'd0,  1, 1, 0,  87381, 0));
    directed_rows.push_back(row(REQ_OFFER, 8'h55, 16'hAAAA, 8'd1,   6'd0,  1, 0, 0,  87381, 0));
    directed_rows.push_back(row(REQ_NONE,  8'hFF, 16'hFFFF, 8'hFF,  6'h3F, 1, 0, 0,  87381, 0));
    directed_rows.push_back(row(REQ_READ,  8'h00, 16'h0000, 8'd0,   6'd0,  1, 0, 0,  87381, 8'hAA));
    directed_rows.push_back(row(REQ_CLEAR, 8'hFF, 16'hFFFF, 8'hFF,  6'h3F, 1, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_READ,  8'h00, 16'h0000, 8'd0,   6'd63, 1, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_OFFER, 8'd10, 16'd9000, 8'd3,   6'd0,  0, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_OFFER, 8'd11, 16'd8000, 8'd3,   6'd0,  0, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_OFFER, 8'd12, 16'd7000, 8'd3,   6'd0,  0, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_OFFER, 8'd13, 16'd6000, 8'd3,   6'd0,  0, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_OFFER, 8'd14, 16'd5000, 8'd65,  6'd0,  0, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_OFFER, 8'd15, 16'd4000, 8'd200, 6'd0,  0, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_READ,  8'h00, 16'h0000, 8'd0,   6'd1,  0, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_READ,  8'h00, 16'h0000, 8'd0,   6'd2,  0, 0, 0,  0,     0));
    directed_rows.push_back(row(REQ_OFFER, 8'd16, 16'd0,    8'd64,  6'd0,  0, 0, 0,  0,     0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) issue_request(directed_rows[i]);

    issued = 0;
    batch_no = 0;
    while (issued < RANDOM_ITEMS) begin
      drain_results();
      case (batch_no % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      batch_no++;
      if ($urandom_range(0, 3) != 0) begin
        r = row(REQ_CLEAR, ID_W'($urandom), PROF_W'($urandom), DLIN_W'($urandom),
                SLOT_W'($urandom), 0, 0, 0, 0, 0);
        issue_request(r);
        issued++;
      end
      batch_len = $urandom_range(30, 110);
      profit_level = $urandom_range(40000, 65535);
      for (int n = 0; n < batch_len && issued < RANDOM_ITEMS; n++) begin
        r = row(REQ_OFFER, ID_W'($urandom), PROF_W'($urandom), DLIN_W'($urandom),
                SLOT_W'($urandom), 0, 0, 0, 0, 0);
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          r.id = ($urandom_range(0, 31) == 0) ? 8'd0 : ID_W'($urandom_range(1, 255));
          case ($urandom_range(0, 19))
            0: r.deadline = 8'd0;
            1: r.deadline = DLIN_W'($urandom_range(65, 255));
            default: r.deadline = DLIN_W'($urandom_range(1, 64));
          endcase
          profit_level = profit_level - $urandom_range(0, 600);
          if (profit_level < 0) profit_level = 0;
          if ($urandom_range(0, 9) != 0) r.profit = PROF_W'(profit_level);
        end else if (pick < 92) begin
          r.rt = REQ_READ;
        end else if (pick < 97) begin
          r.rt = REQ_NONE;
        end else begin
          r.rt = REQ_CLEAR;
        end
        issue_request(r);
        issued++;
      end
    end

    in_valid <= 1'b0;
    rx_stall_pct = 0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/djss_pkg.sv
rtl/core/djss_ram.sv
rtl/core/djss_ctrl.sv
rtl/core/djss_datapath.sv
rtl/core/deadline_job_slot_scheduler.sv
test/tb_deadline_job_slot_scheduler.sv
